[hdl/tcp_pkg.sv]
// ----------------------------------------------------------------------------
// tcp_pkg: shared types and constants of the text cell to pixel stream block
// Holds the frame geometry, the request codes, the channel payload structs
// and the byte packing function used by the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

  // Frame geometry.
  localparam int TEXT_ROWS    = 12;
  localparam int TEXT_COLS    = 16;
  localparam int GLYPH_HEIGHT = 16;
  localparam int PAD_LINES    = 8;

  localparam int LINE_BYTES   = 25;
  localparam logic [7:0] PAD_BYTE = 8'hFF;
  localparam int CELL_COUNT   = TEXT_ROWS * TEXT_COLS;
  localparam int TEXT_LINES   = TEXT_ROWS * GLYPH_HEIGHT;
  localparam int TOTAL_LINES  = TEXT_LINES + PAD_LINES;
  localparam int PAIR_BYTES   = (TEXT_COLS / 2) * 3;
  localparam int GLYPH_DEPTH  = 4096;

  // Counter and address widths.
  localparam int CELL_AW  = $clog2(CELL_COUNT);
  localparam int GLYPH_AW = $clog2(GLYPH_DEPTH);
  localparam int LINE_W   = $clog2(TOTAL_LINES + 1);
  localparam int TROW_W   = $clog2(TEXT_ROWS + 1);
  localparam int BYTE_W   = $clog2(LINE_BYTES);
  localparam int PAIR_W   = $clog2((LINE_BYTES - 1) / 3 + 1);
  localparam int GROW_W   = 4;

  // Request codes.
  localparam logic [1:0] REQ_CELL  = 2'd0;
  localparam logic [1:0] REQ_GLYPH = 2'd1;
  localparam logic [1:0] REQ_EMIT  = 2'd2;

  // Position of a byte within a pair of glyph rows.
  localparam logic [1:0] BYTE_LEFT  = 2'd0;
  localparam logic [1:0] BYTE_MID   = 2'd1;
  localparam logic [1:0] BYTE_RIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  cell_index;
    logic [7:0]  char_code;
    logic [3:0]  glyph_row;
    logic [11:0] glyph_bits;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_last;
  } out_t;

  // Per-byte control carried down the pipeline.
  typedef struct packed {
    logic       pad;
    logic [1:0] k;
    logic       last;
  } ctl_t;

  // Current scan position as seen by the cell store read.
  typedef struct packed {
    ctl_t               ctl;
    logic [GROW_W-1:0]  grow;
    logic [CELL_AW-1:0] cell_a;
    logic [CELL_AW-1:0] cell_b;
  } scan_t;

  // Select one byte of the 24-pixel word formed by two glyph rows.
  function automatic logic [7:0] pack_byte(input logic [11:0] left,
                                           input logic [11:0] right,
                                           input ctl_t        ctl);
    logic [7:0] b;
    b = PAD_BYTE;
    if (!ctl.pad) begin
      unique case (ctl.k)
        BYTE_LEFT:  b = left[11:4];
        BYTE_MID:   b = {left[3:0], right[11:8]};
        BYTE_RIGHT: b = right[7:0];
        default:    b = PAD_BYTE;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/tcp_ram.sv]
// ----------------------------------------------------------------------------
// tcp_ram: generic single-write, dual-read synchronous RAM
// Read data is registered and held while the read enable is low. On a
// same-cycle collision the read returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  // Write port and read-first registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

`default_nettype wire

[hdl/tcp_scan.sv]
// ----------------------------------------------------------------------------
// tcp_scan: frame position counters
// Tracks line, glyph row, text row, byte in line and byte within a pair,
// and derives the two cell addresses and the byte control for each emit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_scan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  output tcp_pkg::scan_t     scan
);

  localparam int SUM_W = tcp_pkg::CELL_AW + 6;

  logic [tcp_pkg::LINE_W-1:0] line_r, line_nxt;
  logic [tcp_pkg::GROW_W-1:0] grow_r, grow_nxt;
  logic [tcp_pkg::TROW_W-1:0] trow_r, trow_nxt;
  logic [tcp_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [tcp_pkg::PAIR_W-1:0] pair_r, pair_nxt;
  logic [1:0]                 k_r, k_nxt;

  logic             line_end;
  logic             frame_end;
  logic             in_text;
  logic [SUM_W-1:0] cell_sum;

  assign line_end  = (byte_r == tcp_pkg::BYTE_W'(tcp_pkg::LINE_BYTES - 1));
  assign frame_end = (line_r == tcp_pkg::LINE_W'(tcp_pkg::TOTAL_LINES - 1));
  assign in_text   = (line_r < tcp_pkg::LINE_W'(tcp_pkg::TEXT_LINES));

  // Counter advance on each emitted byte.
  always_comb begin
    line_nxt = line_r;
    grow_nxt = grow_r;
    trow_nxt = trow_r;
    byte_nxt = byte_r;
    pair_nxt = pair_r;
    k_nxt    = k_r;
    if (step) begin
      if (line_end) begin
        byte_nxt = '0;
        pair_nxt = '0;
        k_nxt    = tcp_pkg::BYTE_LEFT;
        if (frame_end) begin
          line_nxt = '0;
          grow_nxt = '0;
          trow_nxt = '0;
        end else begin
          line_nxt = line_r + 1'b1;
          if (grow_r == tcp_pkg::GROW_W'(tcp_pkg::GLYPH_HEIGHT - 1)) begin
            grow_nxt = '0;
            if (in_text) begin
              trow_nxt = trow_r + 1'b1;
            end
          end else begin
            grow_nxt = grow_r + 1'b1;
          end
        end
      end else begin
        byte_nxt = byte_r + 1'b1;
        if (k_r == tcp_pkg::BYTE_RIGHT) begin
          k_nxt    = tcp_pkg::BYTE_LEFT;
          pair_nxt = pair_r + 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      grow_r <= '0;
      trow_r <= '0;
      byte_r <= '0;
      pair_r <= '0;
      k_r    <= tcp_pkg::BYTE_LEFT;
    end else begin
      line_r <= line_nxt;
      grow_r <= grow_nxt;
      trow_r <= trow_nxt;
      byte_r <= byte_nxt;
      pair_r <= pair_nxt;
      k_r    <= k_nxt;
    end
  end

  // Left cell of the current pair; pad bytes read cell zero harmlessly.
  assign cell_sum = SUM_W'(trow_r) * SUM_W'(tcp_pkg::TEXT_COLS)
                  + SUM_W'({pair_r, 1'b0});

  always_comb begin
    scan.ctl.pad  = !in_text || (byte_r >= tcp_pkg::BYTE_W'(tcp_pkg::PAIR_BYTES));
    scan.ctl.k    = k_r;
    scan.ctl.last = frame_end && line_end;
    scan.grow     = grow_r;
    if (scan.ctl.pad) begin
      scan.cell_a = '0;
      scan.cell_b = '0;
    end else begin
      scan.cell_a = cell_sum[tcp_pkg::CELL_AW-1:0];
      scan.cell_b = cell_sum[tcp_pkg::CELL_AW-1:0] + 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/text_cell_to_pixel_stream_top.sv]
// ----------------------------------------------------------------------------
// text_cell_to_pixel_stream_top: text-mode character generator
// Character and glyph stores feeding a byte stream for a monochrome panel.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries three kinds of
//   request: a cell write, a glyph row write, and an emit. Writes go
//   straight into the character store or the glyph store and produce no
//   result transaction. Each emit produces one transaction on the output
//   channel (out_valid, out_ready, out_data) carrying the next frame byte;
//   frame_last marks the final byte of the frame, after which the scan
//   wraps to the start.
//   An emit passes a character store read, a glyph store read and the
//   output register, in that order, before its result is offered on the
//   output channel.
//   One request is accepted per cycle, sustained, while the receiver keeps
//   up; the three-stage pipeline stalls behind a waiting result.
//   When the receiver stalls, the pipeline fills its empty stages first,
//   so up to two further emits are taken behind a waiting result before
//   in_ready drops; writes are taken as long as in_ready is high.
//   Reset clears the scan position to the first byte of the frame and
//   empties the pipeline; the store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_to_pixel_stream_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tcp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcp_pkg::out_t      out_data
);

  logic en1, en2, en_out;
  logic in_acc;
  logic emit_acc;
  logic cell_wr;
  logic glyph_wr;

  tcp_pkg::scan_t scan;

  logic           s1_valid_r;
  tcp_pkg::ctl_t  s1_ctl_r;
  logic [tcp_pkg::GROW_W-1:0] s1_grow_r;
  logic           s2_valid_r;
  tcp_pkg::ctl_t  s2_ctl_r;
  logic           out_valid_r;
  tcp_pkg::out_t  out_data_r;

  logic [7:0]  code_a, code_b;
  logic [11:0] glyph_a, glyph_b;
  logic [tcp_pkg::GLYPH_AW-1:0] glyph_rd_a, glyph_rd_b;

  // Stage enables: a stage moves when the next one moves or is empty.
  assign en_out   = !out_valid_r || out_ready;
  assign en2      = en_out || !s2_valid_r;
  assign en1      = en2 || !s1_valid_r;
  assign in_ready = en1;

  // Request decode.
  assign in_acc   = in_valid && in_ready;
  assign emit_acc = in_acc && (in_data.req_type == tcp_pkg::REQ_EMIT);
  assign cell_wr  = in_acc && (in_data.req_type == tcp_pkg::REQ_CELL)
                  && ({1'b0, in_data.cell_index} < 9'(tcp_pkg::CELL_COUNT));
  assign glyph_wr = in_acc && (in_data.req_type == tcp_pkg::REQ_GLYPH);

  // Scan position counters.
  tcp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (emit_acc),
    .scan  (scan)
  );

  // Character store: both cells of the pair are read together.
  tcp_ram #(
    .WIDTH (8),
    .DEPTH (tcp_pkg::CELL_COUNT)
  ) u_cell_ram (
    .clk       (clk),
    .wr_en     (cell_wr),
    .wr_addr   (in_data.cell_index[tcp_pkg::CELL_AW-1:0]),
    .wr_data   (in_data.char_code),
    .rd_en     (en1),
    .rd_addr_a (scan.cell_a),
    .rd_addr_b (scan.cell_b),
    .rd_data_a (code_a),
    .rd_data_b (code_b)
  );

  // Glyph store addressed by code and glyph row.
  assign glyph_rd_a = {code_a, s1_grow_r};
  assign glyph_rd_b = {code_b, s1_grow_r};

  tcp_ram #(
    .WIDTH (12),
    .DEPTH (tcp_pkg::GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk       (clk),
    .wr_en     (glyph_wr),
    .wr_addr   ({in_data.char_code, in_data.glyph_row}),
    .wr_data   (in_data.glyph_bits),
    .rd_en     (en2),
    .rd_addr_a (glyph_rd_a),
    .rd_addr_b (glyph_rd_b),
    .rd_data_a (glyph_a),
    .rd_data_b (glyph_b)
  );

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= emit_acc;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Pipeline payload, kept in step with the store read registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ctl_r  <= scan.ctl;
      s1_grow_r <= scan.grow;
    end
    if (en2) begin
      s2_ctl_r <= s1_ctl_r;
    end
    if (en_out) begin
      out_data_r.pixel_byte <= tcp_pkg::pack_byte(glyph_a, glyph_b, s2_ctl_r);
      out_data_r.frame_last <= s2_ctl_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[tb/text_cell_to_pixel_stream_top_tb.sv]
// ----------------------------------------------------------------------------
// text_cell_to_pixel_stream_top_tb: self-checking bench for the character
// generator.
// Fills the character and glyph stores, then sends a mix of cell writes,
// glyph row writes, ignored requests and emits. Both channels idle in random
// bursts. Every frame byte that comes back is checked against a local
// prediction of the scan, which is kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module text_cell_to_pixel_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1130;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tcp_pkg::in_t  in_data  = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tcp_pkg::out_t out_data;

  // Requests still to be driven, in order.
  tcp_pkg::in_t  pending_reqs[$];
  // Frame bytes predicted but not yet seen on the output channel.
  tcp_pkg::out_t expected_bytes[$];

  // Predicted contents of the block.
  logic [7:0]  text_codes [tcp_pkg::CELL_COUNT];
  logic [11:0] glyph_rows [tcp_pkg::GLYPH_DEPTH];
  int          scan_line;
  int          scan_byte;

  // Bookkeeping used while the stimulus is built.
  bit          glyph_seen [tcp_pkg::GLYPH_DEPTH];
  bit          code_ready [256];
  logic [7:0]  ready_codes[$];

  int error_count   = 0;
  int bytes_checked = 0;
  int last_flags    = 0;
  int cell_writes   = 0;
  int glyph_writes  = 0;
  int ignored_reqs  = 0;
  int stall_cycles  = 0;

  int in_gap = 0, in_stretch = 0, in_rate = 0;
  int out_gap = 0, out_stretch = 0, out_rate = 0;

  text_cell_to_pixel_stream_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Byte of the frame at a given line and byte position.
  function automatic logic [7:0] frame_byte_at(input int line, input int pos);
    int          trow;
    logic [3:0]  grow;
    int          first_cell;
    logic [1:0]  k;
    logic [11:0] left;
    logic [11:0] right;
    if (line >= tcp_pkg::TEXT_LINES || pos >= tcp_pkg::PAIR_BYTES) begin
      return tcp_pkg::PAD_BYTE;
    end
    trow       = line / tcp_pkg::GLYPH_HEIGHT;
    grow       = 4'(line % tcp_pkg::GLYPH_HEIGHT);
    first_cell = trow * tcp_pkg::TEXT_COLS + (pos / 3) * 2;
    k          = 2'(pos % 3);
    left       = glyph_rows[{text_codes[first_cell], grow}];
    right      = glyph_rows[{text_codes[first_cell + 1], grow}];
    case (k)
      tcp_pkg::BYTE_LEFT: return left[11:4];
      tcp_pkg::BYTE_MID:  return {left[3:0], right[11:8]};
      default:            return right[7:0];
    endcase
  endfunction

  // Apply one accepted request to the predicted state.
  task automatic track_request(input tcp_pkg::in_t req);
    tcp_pkg::out_t res;
    case (req.req_type)
      tcp_pkg::REQ_CELL: begin
        if (req.cell_index < tcp_pkg::CELL_COUNT) begin
          text_codes[req.cell_index] = req.char_code;
          cell_writes++;
        end else begin
          ignored_reqs++;
        end
      end
      tcp_pkg::REQ_GLYPH: begin
        glyph_rows[{req.char_code, req.glyph_row}] = req.glyph_bits;
        glyph_writes++;
      end
      tcp_pkg::REQ_EMIT: begin
        res.pixel_byte = frame_byte_at(scan_line, scan_byte);
        res.frame_last = (scan_line == tcp_pkg::TOTAL_LINES - 1 &&
                          scan_byte == tcp_pkg::LINE_BYTES - 1);
        expected_bytes.push_back(res);
        scan_byte++;
        if (scan_byte == tcp_pkg::LINE_BYTES) begin
          scan_byte = 0;
          scan_line = (scan_line == tcp_pkg::TOTAL_LINES - 1) ? 0 : scan_line + 1;
        end
      end
      default: begin
        ignored_reqs++;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic tcp_pkg::in_t random_req();
    tcp_pkg::in_t r;
    r.req_type   = 2'($urandom_range(0, 3));
    r.cell_index = 8'($urandom_range(0, 255));
    r.char_code  = 8'($urandom_range(0, 255));
    r.glyph_row  = 4'($urandom_range(0, 15));
    r.glyph_bits = 12'($urandom_range(0, 4095));
    return r;
  endfunction

  // A glyph row write; a code becomes usable once all its rows are written.
  task automatic add_glyph(input logic [7:0] code, input logic [3:0] row,
                           input logic [11:0] bits);
    tcp_pkg::in_t r;
    bit  full;
    r            = random_req();
    r.req_type   = tcp_pkg::REQ_GLYPH;
    r.char_code  = code;
    r.glyph_row  = row;
    r.glyph_bits = bits;
    pending_reqs.push_back(r);
    glyph_seen[{code, row}] = 1'b1;
    if (!code_ready[code]) begin
      full = 1'b1;
      for (int i = 0; i < tcp_pkg::GLYPH_HEIGHT; i++) begin
        if (!glyph_seen[{code, 4'(i)}]) full = 1'b0;
      end
      if (full) begin
        code_ready[code] = 1'b1;
        ready_codes.push_back(code);
      end
    end
  endtask

  task automatic add_cell(input logic [7:0] idx, input logic [7:0] code);
    tcp_pkg::in_t r;
    r            = random_req();
    r.req_type   = tcp_pkg::REQ_CELL;
    r.cell_index = idx;
    r.char_code  = code;
    pending_reqs.push_back(r);
  endtask

  task automatic add_emit();
    tcp_pkg::in_t r;
    r          = random_req();
    r.req_type = tcp_pkg::REQ_EMIT;
    pending_reqs.push_back(r);
  endtask

  task automatic add_unused();
    tcp_pkg::in_t r;
    r          = random_req();
    r.req_type = REQ_UNUSED;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [7:0] any_ready_code();
    return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
  endfunction

  // Idle rate for the next stretch, in percent; zero gives a stretch with
  // no idling at all.
  function automatic int pick_idle_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 45;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests and tracks each accepted transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_request(pending_reqs.pop_front());
      end
      if (in_stretch == 0) begin
        in_stretch = $urandom_range(30, 150);
        in_rate    = pick_idle_rate();
      end else begin
        in_stretch--;
      end
      // A transaction that was not taken stays on the port unchanged.
      if (!(in_valid && !in_ready)) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL &&
                     $urandom_range(1, 100) <= in_rate) begin
          in_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs[0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction and stalls the output at random.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] mismatch %0d: %s", $realtime, error_count, msg);
    end
  endtask

  always @(posedge clk) begin
    tcp_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b",
                               out_data.pixel_byte, out_data.frame_last));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want.frame_last) last_flags++;
          if (out_data.pixel_byte !== want.pixel_byte) begin
            flag_error($sformatf("byte %0d: pixel_byte expected %02h, got %02h",
                                 bytes_checked, want.pixel_byte, out_data.pixel_byte));
          end
          if (out_data.frame_last !== want.frame_last) begin
            flag_error($sformatf("byte %0d: frame_last expected %0b, got %0b",
                                 bytes_checked, want.frame_last, out_data.frame_last));
          end
        end
      end
      if (out_stretch == 0) begin
        out_stretch = $urandom_range(30, 150);
        out_rate    = pick_idle_rate();
      end else begin
        out_stretch--;
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (pending_reqs.size() > QUIET_TAIL &&
                   $urandom_range(1, 100) <= out_rate) begin
        out_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("text_cell_to_pixel_stream_top_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int         counted;
    int         pick;
    logic [7:0] code;
    scan_line = 0;
    scan_byte = 0;

    // Load: four complete glyphs, with all-clear and all-set rows among them,
    // then every character cell, so no emit ever reads an unwritten entry.
    for (int row = 0; row < tcp_pkg::GLYPH_HEIGHT; row++) begin
      add_glyph(8'h00, 4'(row), 12'h000);
      add_glyph(8'hFF, 4'(row), 12'hFFF);
      add_glyph(8'hA5, 4'(row), 12'($urandom_range(0, 4095)));
      add_glyph(8'h5A, 4'(row), 12'($urandom_range(0, 4095)));
    end
    for (int i = 0; i < tcp_pkg::CELL_COUNT; i++) begin
      add_cell(8'(i), any_ready_code());
    end

    // Directed part: extremes, ignored requests and writes mid-frame.
    add_glyph(8'hA5, 4'd0, 12'hFFF);
    add_glyph(8'h5A, 4'd15, 12'h000);
    add_cell(8'd0, 8'hFF);
    add_cell(8'd1, 8'h00);
    add_cell(8'(tcp_pkg::CELL_COUNT - 1), 8'hA5);
    add_cell(8'(tcp_pkg::CELL_COUNT), 8'hA5);
    add_cell(8'd255, 8'h00);
    add_unused();
    // A lone glyph row of a code that no cell holds: stored, never shown.
    add_glyph(8'h3C, 4'd7, 12'hABC);
    repeat (6) add_emit();
    // The next pair is cells 4 and 5; rewrite one before it is scanned.
    add_cell(8'd4, 8'h5A);
    add_glyph(8'h5A, 4'd0, 12'h5A5);
    repeat (3) add_emit();
    add_unused();
    add_emit();

    // Random part: mostly emits and well-formed writes, some noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_emit();
        counted++;
      end else if (pick < 67) begin
        add_glyph(any_ready_code(), 4'($urandom_range(0, 15)),
                  12'($urandom_range(0, 4095)));
        counted++;
      end else if (pick < 79) begin
        add_cell(8'($urandom_range(0, tcp_pkg::CELL_COUNT - 1)), any_ready_code());
        counted++;
      end else if (pick < 83) begin
        add_cell(8'($urandom_range(tcp_pkg::CELL_COUNT, 255)),
                 8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        add_unused();
      end else if (pick < 93) begin
        add_glyph(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  12'($urandom_range(0, 4095)));
        counted++;
      end else begin
        // A whole new glyph, then put it on screen.
        code = 8'($urandom_range(0, 255));
        for (int row = 0; row < tcp_pkg::GLYPH_HEIGHT; row++) begin
          add_glyph(code, 4'(row), 12'($urandom_range(0, 4095)));
        end
        add_cell(8'($urandom_range(0, tcp_pkg::CELL_COUNT - 1)), code);
        counted += tcp_pkg::GLYPH_HEIGHT + 1;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d frame bytes (%0d flagged last), scan now at line %0d byte %0d.",
             bytes_checked, last_flags, scan_line, scan_byte);
    $display("Applied %0d cell writes, %0d glyph writes and %0d ignored requests; %0d errors.",
             cell_writes, glyph_writes, ignored_reqs, error_count);
    if (error_count == 0) begin
      $display("text_cell_to_pixel_stream_top_tb: clean");
    end else begin
      $display("text_cell_to_pixel_stream_top_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tcp_pkg.sv
hdl/tcp_ram.sv
hdl/tcp_scan.sv
hdl/text_cell_to_pixel_stream_top.sv
tb/text_cell_to_pixel_stream_top_tb.sv
